@@ rtl/core/tagged_frame_builder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// tagged_frame_builder_unit_defines
// Assertion macros shared by the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef TAGGED_FRAME_BUILDER_UNIT_DEFINES_SVH
`define TAGGED_FRAME_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication
`define TFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/tfb_pkg.sv @@
// ----------------------------------------------------------------------------
// tfb_pkg
// Types, codes and constants of the tagged frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

   // command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // register indexes
   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_SENDER   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RECEIVER = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DIR      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PROTO    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CONTENT  = 3'd4;

   // reset values
   localparam logic [7:0] RST_SENDER   = 8'd1;
   localparam logic [7:0] RST_RECEIVER = 8'd2;
   localparam logic [7:0] RST_DIR      = 8'd1;
   localparam logic [7:0] RST_PROTO    = 8'd1;
   localparam logic [7:0] RST_CONTENT  = 8'd1;

   // fixed frame bytes
   localparam logic [7:0] SYNC0_BYTE = 8'hAA;
   localparam logic [7:0] SYNC1_BYTE = 8'h55;
   localparam logic [7:0] TAIL0_BYTE = 8'hCC;
   localparam logic [7:0] TAIL1_BYTE = 8'h33;
   localparam logic [7:0] LEN_OFFSET = 8'd3;

   // byte positions within a frame
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_SYNC0   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC1   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SENDER  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RECV    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIR     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_PROTO   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CLEN    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CVER    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_TAG     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DATA    = 4'd9;   // length or payload byte
   localparam logic [STEP_W-1:0] STEP_SUM_LO  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_SUM_HI  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_TAIL0   = 4'd12;
   localparam logic [STEP_W-1:0] STEP_TAIL1   = 4'd13;

   typedef struct packed {
      logic [7:0] sender;
      logic [7:0] receiver;
      logic [7:0] direction;
      logic [7:0] protocol;
      logic [7:0] content;
   } cfg_type;

   // one run of output beats
   typedef struct packed {
      logic [STEP_W-1:0] start;
      logic              trailer;
      logic [7:0]        sender;
      logic [7:0]        receiver;
      logic [7:0]        direction;
      logic [7:0]        protocol;
      logic [7:0]        clen;
      logic [7:0]        cver;
      logic [7:0]        tag;
      logic [7:0]        data;
      logic [15:0]       sum;
   } job_type;

   function automatic logic [STEP_W-1:0] last_step(input logic trailer);
      return trailer ? STEP_TAIL1 : STEP_DATA;
   endfunction

endpackage

@@ rtl/core/tagged_frame_builder_unit.sv @@
// ----------------------------------------------------------------------------
// tagged_frame_builder_unit
// Builds tagged telemetry frames as a byte stream.
// ----------------------------------------------------------------------------
// Input beats on req_: req_tuser is the command (0 start, 1 payload byte);
// a start beat carries tag and payload length, a payload beat one byte.
// Output beats on rsp_: one frame byte each, rsp_tlast on the final tail
// byte (33) of a frame.
// A start beat yields 10 output beats (AA 55 header bytes, content length,
// content version, tag, length), 14 when the length is zero. Each payload
// beat of an open frame yields its echo, plus sum low/high and CC 33 after
// the last one. Payload beats outside a frame are taken and dropped.
// The first output beat of an item goes through the run register, then the result register.
// Throughput: one output beat per cycle while rsp_tready stays high, set by the single result register;
// the next item is taken in the cycle the current run loads its last beat,
// so payload bytes stream at one per cycle while rsp_tready stays high.
// A stalled receiver holds the result register and the run in progress;
// req_tready drops until the run's last beat can load.
// Reset (synchronous) empties the run and result registers, closes any
// frame, clears the sum and restores the header registers to 1,2,1,1,1.
// csr_ writes take effect at the next start beat.
// ----------------------------------------------------------------------------
module tagged_frame_builder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // frame_tag, payload_length, payload_byte
   input  logic                           req_tuser,  // command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // out_byte
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [tfb_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wr_data
);
   import tfb_pkg::*;

   cfg_type cfg;
   job_type job;
   logic    job_valid;
   logic    job_ready;
   logic    item_accept;

   assign req_tready  = job_ready;
   assign item_accept = req_tvalid && job_ready;

   tfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tfb_frame_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_accept (item_accept),
      .item_cmd    (req_tuser),
      .item_tag    (req_tdata[7:0]),
      .item_len    (req_tdata[15:8]),
      .item_byte   (req_tdata[23:16]),
      .job_valid   (job_valid),
      .job         (job)
   );

   tfb_byte_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_ready  (job_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/tfb_csr.sv @@
// ----------------------------------------------------------------------------
// tfb_csr
// Header configuration registers, write only.
// ----------------------------------------------------------------------------
module tfb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tfb_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_wr_data,
   output tfb_pkg::cfg_type                cfg
);
   import tfb_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sender    <= RST_SENDER;
         cfg_ff.receiver  <= RST_RECEIVER;
         cfg_ff.direction <= RST_DIR;
         cfg_ff.protocol  <= RST_PROTO;
         cfg_ff.content   <= RST_CONTENT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SENDER:   cfg_ff.sender    <= csr_wr_data;
            REG_RECEIVER: cfg_ff.receiver  <= csr_wr_data;
            REG_DIR:      cfg_ff.direction <= csr_wr_data;
            REG_PROTO:    cfg_ff.protocol  <= csr_wr_data;
            REG_CONTENT:  cfg_ff.content   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/tfb_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfb_frame_ctrl
// Frame state (open flag, bytes left, running sum) and run builder.
// ----------------------------------------------------------------------------
`include "tagged_frame_builder_unit_defines.svh"

module tfb_frame_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  tfb_pkg::cfg_type  cfg,
   input  logic              item_accept,
   input  logic              item_cmd,
   input  logic [7:0]        item_tag,
   input  logic [7:0]        item_len,
   input  logic [7:0]        item_byte,
   output logic              job_valid,
   output tfb_pkg::job_type  job
);
   import tfb_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] sum_ff, sum_in;

   logic [15:0] start_sum;
   logic [15:0] pay_sum;
   logic [7:0]  pay_left;
   logic        is_start;

   assign is_start  = (item_cmd == CMD_START);
   assign start_sum = 16'({8'd0, cfg.content} + {8'd0, item_tag} + {8'd0, item_len});
   assign pay_sum   = sum_ff + {8'd0, item_byte};
   assign pay_left  = bytes_left_ff - 8'd1;

   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      job_valid     = 1'b0;
      job.sender    = cfg.sender;
      job.receiver  = cfg.receiver;
      job.direction = cfg.direction;
      job.protocol  = cfg.protocol;
      job.clen      = item_len + LEN_OFFSET;
      job.cver      = cfg.content;
      job.tag       = item_tag;
      job.start     = STEP_SYNC0;
      job.data      = item_len;
      job.trailer   = (item_len == 8'd0);
      job.sum       = start_sum;
      if (item_accept) begin
         if (is_start) begin
            job_valid     = 1'b1;
            sum_in        = start_sum;
            bytes_left_in = item_len;
            frame_open_in = (item_len != 8'd0);
         end else if (frame_open_ff) begin
            job_valid     = 1'b1;
            job.start     = STEP_DATA;
            job.data      = item_byte;
            job.trailer   = (pay_left == 8'd0);
            job.sum       = pay_sum;
            sum_in        = pay_sum;
            bytes_left_in = pay_left;
            frame_open_in = (pay_left != 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         sum_ff        <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
      end
   end

   `TFB_ASSERT_NOW(a_closed_empty, clock, reset, !frame_open_ff, bytes_left_ff == 8'd0)
   `TFB_ASSERT_NOW(a_open_nonzero, clock, reset, frame_open_ff, bytes_left_ff != 8'd0)
   `TFB_ASSERT_NOW(a_stray_dropped, clock, reset,
      item_accept && !is_start && !frame_open_ff, !job_valid)

endmodule

@@ rtl/core/tfb_byte_seq.sv @@
// ----------------------------------------------------------------------------
// tfb_byte_seq
// Holds one run and steps it out a beat at a time into the result register.
// ----------------------------------------------------------------------------
`include "tagged_frame_builder_unit_defines.svh"

module tfb_byte_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  tfb_pkg::job_type  job,
   output logic              job_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);
   import tfb_pkg::*;

   job_type           job_ff;
   logic              job_valid_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_last_ff;

   logic              out_load;
   logic              at_last;
   logic [7:0]        beat_byte;

   assign out_load  = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign at_last   = (step_ff == last_step(job_ff.trailer));
   assign job_ready = !job_valid_ff || (out_load && at_last);

   always_comb begin
      unique case (step_ff)
         STEP_SYNC0:  beat_byte = SYNC0_BYTE;
         STEP_SYNC1:  beat_byte = SYNC1_BYTE;
         STEP_SENDER: beat_byte = job_ff.sender;
         STEP_RECV:   beat_byte = job_ff.receiver;
         STEP_DIR:    beat_byte = job_ff.direction;
         STEP_PROTO:  beat_byte = job_ff.protocol;
         STEP_CLEN:   beat_byte = job_ff.clen;
         STEP_CVER:   beat_byte = job_ff.cver;
         STEP_TAG:    beat_byte = job_ff.tag;
         STEP_DATA:   beat_byte = job_ff.data;
         STEP_SUM_LO: beat_byte = job_ff.sum[7:0];
         STEP_SUM_HI: beat_byte = job_ff.sum[15:8];
         STEP_TAIL0:  beat_byte = TAIL0_BYTE;
         STEP_TAIL1:  beat_byte = TAIL1_BYTE;
         default:     beat_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new run may load in the same cycle the old one sends its last beat
         if (job_valid) begin
            job_valid_ff <= 1'b1;
         end else if (out_load && at_last) begin
            job_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid) begin
         job_ff  <= job;
         step_ff <= job.start;
      end else if (out_load) begin
         step_ff <= step_ff + 4'd1;
      end
      if (out_load) begin
         rsp_data_ff <= beat_byte;
         rsp_last_ff <= (step_ff == STEP_TAIL1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TFB_ASSERT_NOW(a_job_when_free, clock, reset, job_valid, job_ready)
   `TFB_ASSERT_NOW(a_step_in_run, clock, reset, job_valid_ff,
      step_ff <= last_step(job_ff.trailer))
   `TFB_ASSERT_NEXT(a_run_retires, clock, reset, out_load && at_last && !job_valid,
      !job_valid_ff)
   `TFB_ASSERT_NOW(a_last_is_tail, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_data_ff == TAIL1_BYTE)

endmodule

@@ tb/frame_stream_checker.sv @@
// ----------------------------------------------------------------------------
// frame_stream_checker
// Watches the input, output and register ports of the frame builder, works
// out the frame bytes each accepted input beat must produce and compares
// every accepted output beat, in order, with the oldest byte still due.
// ----------------------------------------------------------------------------
module frame_stream_checker
   import tfb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,   // frame_tag, payload_length, payload_byte
   input  logic                 req_tuser,   // command
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [7:0]           rsp_tdata,   // out_byte
   input  logic                 rsp_tlast,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wr_data,
   output int                   mismatches,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] value;
      logic       frame_end;
   } frame_beat_type;

   frame_beat_type frame_bytes_due [$];
   cfg_type     hdr;
   logic        open_frame   = 1'b0;
   logic [7:0]  payload_left = '0;
   logic [15:0] frame_sum    = '0;
   int          bad          = 0;

   task automatic queue_byte(input logic [7:0] value, input logic last);
      frame_bytes_due.push_back(frame_beat_type'{value, last});
   endtask

   task automatic queue_trailer();
      queue_byte(frame_sum[7:0], 1'b0);
      queue_byte(frame_sum[15:8], 1'b0);
      queue_byte(TAIL0_BYTE, 1'b0);
      queue_byte(TAIL1_BYTE, 1'b1);
      open_frame   = 1'b0;
      payload_left = '0;
   endtask

   task automatic predict_frame_bytes(input logic cmd, input logic [23:0] data);
      logic [7:0] tag;
      logic [7:0] len;
      logic [7:0] pb;
      tag = data[7:0];
      len = data[15:8];
      pb  = data[23:16];
      if (cmd == CMD_START) begin
         // a new start simply replaces whatever frame was open
         queue_byte(SYNC0_BYTE, 1'b0);
         queue_byte(SYNC1_BYTE, 1'b0);
         queue_byte(hdr.sender, 1'b0);
         queue_byte(hdr.receiver, 1'b0);
         queue_byte(hdr.direction, 1'b0);
         queue_byte(hdr.protocol, 1'b0);
         queue_byte(len + LEN_OFFSET, 1'b0);
         queue_byte(hdr.content, 1'b0);
         queue_byte(tag, 1'b0);
         queue_byte(len, 1'b0);
         frame_sum    = {8'h00, hdr.content} + {8'h00, tag} + {8'h00, len};
         payload_left = len;
         open_frame   = 1'b1;
         if (len == 8'd0)
            queue_trailer();
      end else if (open_frame) begin
         queue_byte(pb, 1'b0);
         frame_sum    = frame_sum + {8'h00, pb};
         payload_left = payload_left - 8'd1;
         if (payload_left == 8'd0)
            queue_trailer();
      end
   endtask

   always @(posedge clock) begin : watch
      frame_beat_type want;
      if (reset) begin
         hdr = '{sender: RST_SENDER, receiver: RST_RECEIVER, direction: RST_DIR,
                 protocol: RST_PROTO, content: RST_CONTENT};
         open_frame   = 1'b0;
         payload_left = '0;
         frame_sum    = '0;
         frame_bytes_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: beat with nothing due: out_byte %h frame_end %b",
                        $time, rsp_tdata, rsp_tlast);
               bad++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.value) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.value, rsp_tdata);
                  bad++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $display("%0t: frame_end expected %b actual %b",
                           $time, want.frame_end, rsp_tlast);
                  bad++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_frame_bytes(req_tuser, req_tdata);
         if (csr_wr_en) begin
            case (csr_index)
               REG_SENDER:   hdr.sender    = csr_wr_data;
               REG_RECEIVER: hdr.receiver  = csr_wr_data;
               REG_DIR:      hdr.direction = csr_wr_data;
               REG_PROTO:    hdr.protocol  = csr_wr_data;
               REG_CONTENT:  hdr.content   = csr_wr_data;
               default: ;
            endcase
         end
      end
      mismatches  <= bad;
      outstanding <= frame_bytes_due.size();
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tagged frame builder: directed frames covering zero
// length, stray payload, restart and mid-frame register writes, then random
// frame sequences under several register settings, with random stalls on
// both streams. Checking is done by frame_stream_checker.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfb_pkg::*;

   localparam int NUM_REG_IDX      = 1 << REG_IDX_W;
   localparam int DRAIN_CYCLES     = 4;
   localparam int LONG_HOLD_BEAT   = 200;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int ITEMS_PER_BATCH  = 32;
   localparam int NUM_BATCHES      = 4;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata   = '0;  // frame_tag, payload_length, payload_byte
   logic                 req_tuser   = CMD_START;  // command
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [7:0]           rsp_tdata;  // out_byte
   logic                 rsp_tlast;
   logic                 csr_wr_en   = 1'b0;
   logic [REG_IDX_W-1:0] csr_index   = '0;
   logic [7:0]           csr_wr_data = '0;

   int mismatches;
   int outstanding;
   int items_sent = 0;
   bit send_idle  = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tagged_frame_builder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   frame_stream_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   task automatic push_item(input logic cmd, input logic [7:0] tag, input logic [7:0] len,
                            input logic [7:0] pb);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pb, len, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (items_sent % 24 == 0)
         send_idle = 1'($urandom_range(0, 1));
   endtask

   task automatic start_frame(input logic [7:0] tag, input logic [7:0] len);
      push_item(CMD_START, tag, len, 8'($urandom_range(0, 255)));
   endtask

   task automatic feed_byte(input logic [7:0] pb);
      push_item(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pb);
   endtask

   // hold the sender until every due byte is out, then let a stray beat settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // writes every index, the unused ones with junk that must be ignored
   task automatic load_regs(input logic [7:0] snd, input logic [7:0] rcv,
                            input logic [7:0] dir, input logic [7:0] proto,
                            input logic [7:0] cver);
      logic [7:0] vals [NUM_REG_IDX];
      foreach (vals[i])
         vals[i] = 8'($urandom_range(0, 255));
      vals[REG_SENDER]   = snd;
      vals[REG_RECEIVER] = rcv;
      vals[REG_DIR]      = dir;
      vals[REG_PROTO]    = proto;
      vals[REG_CONTENT]  = cver;
      for (int i = 0; i < NUM_REG_IDX; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= i[REG_IDX_W-1:0];
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_reg_value();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_frame();
      int kind;
      int len;
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 8);
         start_frame(8'($urandom_range(0, 255)), 8'(len));
         repeat (len) feed_byte(8'($urandom_range(0, 255)));
      end else if (kind < 16) begin
         // cut short, the next start abandons it
         len = $urandom_range(1, 255);
         start_frame(8'($urandom_range(0, 255)), 8'(len));
         repeat ($urandom_range(0, (len > 6) ? 6 : len - 1))
            feed_byte(8'($urandom_range(0, 255)));
      end else if (kind < 18) begin
         repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(0, 255)));
      end else if (kind < 19) begin
         start_frame(8'($urandom_range(0, 255)), 8'h00);
      end else begin
         wait_drained();
      end
   endtask

   // result side: random stalls per beat, one long hold to back up the input
   initial begin
      int gap;
      int beats;
      bit idle_mode;
      beats = 0;
      idle_mode = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats % 32 == 0)
            idle_mode = 1'($urandom_range(0, 1));
         if (beats == LONG_HOLD_BEAT)
            gap = LONG_HOLD_CYCLES;
         else
            gap = idle_mode ? $urandom_range(0, 9) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         beats++;
      end
   end

   initial begin
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset header values
      start_frame(8'h00, 8'h00);
      start_frame(8'hFF, 8'h02);
      feed_byte(8'h00);
      feed_byte(8'hFF);
      feed_byte(8'hA5);             // no frame open, dropped
      start_frame(8'h5A, 8'hFF);
      repeat (3) feed_byte(8'hFF);
      start_frame(8'h81, 8'h01);    // abandons the long frame
      feed_byte(8'h7E);

      // registers change while a frame waits for payload
      start_frame(8'h3C, 8'h03);
      feed_byte(8'h11);
      wait_drained();
      load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      feed_byte(8'h22);
      feed_byte(8'h33);
      feed_byte(8'hFF);

      start_frame(8'hFF, 8'hFF);
      start_frame(8'hFF, 8'h00);
      start_frame(8'h80, 8'h01);
      feed_byte(8'h80);

      wait_drained();
      load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      start_frame(8'h00, 8'h00);
      start_frame(8'h01, 8'h02);
      feed_byte(8'h00);
      feed_byte(8'h01);

      for (int b = 0; b < NUM_BATCHES; b++) begin
         wait_drained();
         load_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                   pick_reg_value(), pick_reg_value());
         target = items_sent + ITEMS_PER_BATCH;
         while (items_sent < target) random_frame();
      end

      wait_drained();
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
